// File: design/bmpu_pkg.sv
// Shared types, codes and constants for the BMP pixel unpacker.
package bmpu_pkg;

  // Default image size limits.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Fixed field widths of the result beat.
  localparam int DIM_W = 13;
  localparam int IDX_W = 24;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Header error codes, also the bit positions in the fault mask.
  localparam logic [2:0] ERR_SIG      = 3'd0;
  localparam logic [2:0] ERR_HDR_SIZE = 3'd1;
  localparam logic [2:0] ERR_FSIZE    = 3'd2;
  localparam logic [2:0] ERR_PLANES   = 3'd3;
  localparam logic [2:0] ERR_BPP      = 3'd4;
  localparam logic [2:0] ERR_COMPRESS = 3'd5;
  localparam logic [2:0] ERR_OFFSET   = 3'd6;
  localparam logic [2:0] ERR_LARGE    = 3'd7;

  // File positions of the last byte of each checked header field.
  localparam logic [31:0] POS_SIG      = 32'd1;
  localparam logic [31:0] POS_FSIZE    = 32'd5;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_HDR_SIZE = 32'd17;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_BPP      = 32'd29;
  localparam logic [31:0] POS_COMPRESS = 32'd33;
  localparam logic [31:0] POS_END      = 32'd53;

  // Expected header contents.
  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] PLANES_ONE   = 16'd1;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [31:0] HEADER_BYTES = 32'd54;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]       result_kind;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [2:0]       error_code;
  } res_t;

endpackage

// File: design/bmpu_in_if.sv
// Byte stream channel into the BMP pixel unpacker.
interface bmpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// File: design/bmpu_out_if.sv
// Result channel out of the BMP pixel unpacker.
interface bmpu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [23:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  error_code;

  modport source (
    output valid, output result_kind, output pixel_index, output red, output green,
    output blue, output last_pixel, output image_width, output image_height,
    output error_code, input ready
  );
  modport sink (
    input valid, input result_kind, input pixel_index, input red, input green,
    input blue, input last_pixel, input image_width, input image_height,
    input error_code, output ready
  );
endinterface

// File: design/bmpu_in_reg.sv
// Input register stage that holds one byte beat for the parser.
module bmpu_in_reg
  import bmpu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bmpu_in_if.sink stream,
  input  logic  take,
  output logic  held,
  output beat_t beat
);

  // The stage refills in the same cycle that the parser takes its beat.
  assign stream.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      beat.data_byte   <= stream.data_byte;
      beat.frame_start <= stream.frame_start;
    end
  end

endmodule

// File: design/bmpu_core.sv
// Header parser, pixel assembler and frame buffer index generator.
module bmpu_core
  import bmpu_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  beat_t beat,
  output logic  has_result,
  output res_t  res
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  logic [31:0]      pos, pos_c, pos_next;
  logic [1:0]       phase, phase_c, phase_next;
  logic [31:0]      shift, shift_c, shift_next;
  logic [31:0]      offset, offset_c, offset_next;
  logic [31:0]      fsize, fsize_c, fsize_next;
  logic [WW-1:0]    width, width_c, width_next;
  logic [HW-1:0]    height, height_c, height_next;
  logic [1:0]       chan, chan_c, chan_next;
  logic [7:0]       blue, blue_next;
  logic [7:0]       green, green_next;
  logic [WW-1:0]    col, col_c, col_next;
  logic [HW-1:0]    row, row_c, row_next;
  logic [IDX_W-1:0] rbase, rbase_c, rbase_next;
  logic [7:0]       fault, fault_c, fault_next;

  logic [31:0]      word;
  logic [7:0]       fault_all;
  logic [2:0]       err;
  logic [PW-1:0]    area;
  logic             data_en;
  logic             pad_skip;
  logic [WW-1:0]    col_eff;
  logic [WW-1:0]    col_inc;
  logic [HW-1:0]    row_inc;

  // A frame start makes the current byte byte zero of a fresh file.
  always_comb begin
    pos_c    = beat.frame_start ? '0 : pos;
    phase_c  = beat.frame_start ? PH_HEADER : phase;
    shift_c  = beat.frame_start ? '0 : shift;
    offset_c = beat.frame_start ? '0 : offset;
    fsize_c  = beat.frame_start ? '0 : fsize;
    width_c  = beat.frame_start ? '0 : width;
    height_c = beat.frame_start ? '0 : height;
    chan_c   = beat.frame_start ? '0 : chan;
    col_c    = beat.frame_start ? '0 : col;
    row_c    = beat.frame_start ? '0 : row;
    rbase_c  = beat.frame_start ? '0 : rbase;
    fault_c  = beat.frame_start ? '0 : fault;
  end

  // Header field values and the fault summary at the end of the header.
  assign word = {beat.data_byte, shift_c[31:8]};
  assign area = PW'(height_c - HW'(1)) * PW'(width_c);

  always_comb begin
    fault_all = fault_c;
    if (fsize_c < offset_c) begin
      fault_all[ERR_FSIZE] = 1'b1;
    end
    if (offset_c < HEADER_BYTES) begin
      fault_all[ERR_OFFSET] = 1'b1;
    end
    // Lowest failing check wins.
    err = ERR_LARGE;
    for (int i = 7; i >= 0; i--) begin
      if (fault_all[i]) begin
        err = 3'(i);
      end
    end
  end

  // Next state and result for one byte.
  always_comb begin
    pos_next    = pos_c + 32'd1;
    phase_next  = phase_c;
    shift_next  = shift_c;
    offset_next = offset_c;
    fsize_next  = fsize_c;
    width_next  = width_c;
    height_next = height_c;
    chan_next   = chan_c;
    blue_next   = blue;
    green_next  = green;
    col_next    = col_c;
    row_next    = row_c;
    rbase_next  = rbase_c;
    fault_next  = fault_c;
    has_result  = 1'b0;
    res         = '0;
    data_en     = 1'b0;
    pad_skip    = 1'b0;
    col_eff     = col_c;
    col_inc     = '0;
    row_inc     = '0;

    case (phase_c)
      PH_HEADER: begin
        shift_next = word;
        case (pos_c)
          POS_SIG: begin
            if (word[23:16] != SIG_B || word[31:24] != SIG_M) begin
              fault_next[ERR_SIG] = 1'b1;
            end
          end
          POS_FSIZE: begin
            fsize_next = word;
          end
          POS_OFFSET: begin
            offset_next = word;
          end
          POS_HDR_SIZE: begin
            if (word != INFO_SIZE) begin
              fault_next[ERR_HDR_SIZE] = 1'b1;
            end
          end
          POS_WIDTH: begin
            if (word > 32'(MAX_WIDTH)) begin
              fault_next[ERR_LARGE] = 1'b1;
            end else begin
              width_next = WW'(word);
            end
          end
          POS_HEIGHT: begin
            if (word > 32'(MAX_HEIGHT)) begin
              fault_next[ERR_LARGE] = 1'b1;
            end else begin
              height_next = HW'(word);
            end
          end
          POS_PLANES: begin
            if (word[31:16] != PLANES_ONE) begin
              fault_next[ERR_PLANES] = 1'b1;
            end
          end
          POS_BPP: begin
            if (word[31:16] != BPP_24) begin
              fault_next[ERR_BPP] = 1'b1;
            end
          end
          POS_COMPRESS: begin
            if (word != '0) begin
              fault_next[ERR_COMPRESS] = 1'b1;
            end
          end
          POS_END: begin
            has_result = 1'b1;
            fault_next = fault_all;
            if (fault_all != '0) begin
              res.result_kind = KIND_REJECT;
              res.error_code  = err;
              phase_next      = PH_IDLE;
            end else begin
              res.result_kind  = KIND_ACCEPT;
              res.image_width  = DIM_W'(width_c);
              res.image_height = DIM_W'(height_c);
              chan_next        = '0;
              col_next         = '0;
              row_next         = '0;
              if (width_c == '0 || height_c == '0) begin
                phase_next = PH_IDLE;
              end else begin
                rbase_next = IDX_W'(area);
                phase_next = PH_SKIP;
              end
            end
          end
          default: begin
          end
        endcase
      end
      PH_SKIP: begin
        if (pos_c == offset_c) begin
          phase_next = PH_DATA;
          data_en    = 1'b1;
        end
      end
      PH_DATA: begin
        data_en = 1'b1;
      end
      default: begin
      end
    endcase

    // Pixel data: row padding, channel gathering and index generation.
    if (data_en) begin
      if (col_c >= width_c) begin
        if (pos_c[1:0] != 2'b00) begin
          pad_skip = 1'b1;
        end else begin
          col_eff = '0;
        end
      end
      if (!pad_skip) begin
        col_next = col_eff;
        case (chan_c)
          2'd0: begin
            blue_next = beat.data_byte;
            chan_next = 2'd1;
          end
          2'd1: begin
            green_next = beat.data_byte;
            chan_next  = 2'd2;
          end
          default: begin
            chan_next       = 2'd0;
            col_inc         = col_eff + WW'(1);
            row_inc         = row_c + HW'(1);
            has_result      = 1'b1;
            res.result_kind = KIND_PIXEL;
            res.pixel_index = rbase_c + IDX_W'(col_eff);
            res.red         = beat.data_byte;
            res.green       = green;
            res.blue        = blue;
            res.last_pixel  = (row_inc == height_c) && (col_inc == width_c);
            col_next        = col_inc;
            if (col_inc == width_c) begin
              row_next = row_inc;
              if (row_inc >= height_c) begin
                phase_next = PH_IDLE;
              end else begin
                rbase_next = rbase_c - IDX_W'(width_c);
              end
            end
          end
        endcase
      end
    end
  end

  // Parser state, updated once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      phase  <= PH_HEADER;
      shift  <= '0;
      offset <= '0;
      fsize  <= '0;
      width  <= '0;
      height <= '0;
      chan   <= '0;
      blue   <= '0;
      green  <= '0;
      col    <= '0;
      row    <= '0;
      rbase  <= '0;
      fault  <= '0;
    end else if (step) begin
      pos    <= pos_next;
      phase  <= phase_next;
      shift  <= shift_next;
      offset <= offset_next;
      fsize  <= fsize_next;
      width  <= width_next;
      height <= height_next;
      chan   <= chan_next;
      blue   <= blue_next;
      green  <= green_next;
      col    <= col_next;
      row    <= row_next;
      rbase  <= rbase_next;
      fault  <= fault_next;
    end
  end

endmodule

// File: design/bmp24_bottom_up_pixel_unpacker_core.sv
// Top level of the 24-bit BMP stream unpacker.
// Takes a BMP file one byte per beat from offset zero (frame_start marks offset zero),
// checks the 54-byte header and returns one header-accepted or header-rejected beat on
// the last header byte, then one pixel beat per three data bytes, addressed into a
// top-down row-major frame buffer with blue, green and red separated. Padding at the
// end of each row is dropped. The block takes one byte every clock cycle while the
// result side keeps up; a byte passes through an input register and a result register,
// and a result is delayed beyond these two registers only while the result side stalls.
// The rate is set by the update of the parser state, once per byte, between those two
// registers.
module bmp24_bottom_up_pixel_unpacker_core
  import bmpu_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic        clk,
  input logic        rst,
  bmpu_in_if.sink    stream,
  bmpu_out_if.source result
);

  logic  held;
  logic  adv;
  beat_t beat;
  logic  has_result;
  res_t  res;
  logic  out_v;
  res_t  res_q;

  // The held byte moves on whenever the result register is free or draining.
  assign adv = held && (!out_v || result.ready);

  bmpu_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .take   (adv),
    .held   (held),
    .beat   (beat)
  );

  bmpu_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (adv),
    .beat       (beat),
    .has_result (has_result),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= has_result;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_q <= '0;
    end else if (adv) begin
      res_q <= res;
    end
  end

  assign result.valid        = out_v;
  assign result.result_kind  = res_q.result_kind;
  assign result.pixel_index  = res_q.pixel_index;
  assign result.red          = res_q.red;
  assign result.green        = res_q.green;
  assign result.blue         = res_q.blue;
  assign result.last_pixel   = res_q.last_pixel;
  assign result.image_width  = res_q.image_width;
  assign result.image_height = res_q.image_height;
  assign result.error_code   = res_q.error_code;

  // An empty input register always takes a new byte.
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !held |-> stream.ready)
    else $error("input register empty but not ready");

  // The result register only changes when a byte is processed.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(res_q))
    else $error("result register changed without a byte");

  // An accepted header never reports a width beyond the limit.
  a_width_limit: assert property (@(posedge clk) disable iff (rst)
    (out_v && res_q.result_kind == KIND_ACCEPT) |-> (res_q.image_width <= 13'(MAX_WIDTH)))
    else $error("accepted width above limit");

endmodule

// File: tb/bmp24_bottom_up_pixel_unpacker_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the BMP stream unpacker: generated files in, results checked.
module bmp24_bottom_up_pixel_unpacker_core_tb
  import bmpu_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int TOTAL_BYTES  = 1150;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_IDLE     = 10;

  // Parser phases of the predictor.
  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmpu_in_if  stream_if ();
  bmpu_out_if result_if ();

  bmp24_bottom_up_pixel_unpacker_core dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // File bytes waiting to be sent and result beats waiting to arrive.
  beat_t file_bytes_q[$];
  res_t  decoded_q[$];

  int error_count  = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int hold_left    = 0;
  int next_hold_at = 10;
  int send_wait    = 0;
  int take_wait    = 0;
  bit send_burst   = 1'b0;
  bit take_burst   = 1'b0;
  logic byte_taken   = 1'b0;
  logic result_taken = 1'b0;

  // Decoder state mirrored by the predictor.
  logic [31:0] file_pos;
  phase_t      phase;
  logic [63:0] hdr_window;
  logic [31:0] pix_offset;
  logic [31:0] file_size;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [1:0]  chan_cnt;
  logic [7:0]  held_b;
  logic [7:0]  held_g;
  logic [31:0] col_cnt;
  logic [31:0] row_cnt;
  logic [23:0] row_base;
  logic [7:0]  fault_bits;

  function automatic void decoder_restart();
    file_pos   = '0;
    phase      = PH_HEADER;
    hdr_window = '0;
    pix_offset = '0;
    file_size  = '0;
    img_w      = '0;
    img_h      = '0;
    chan_cnt   = '0;
    held_b     = '0;
    held_g     = '0;
    col_cnt    = '0;
    row_cnt    = '0;
    row_base   = '0;
    fault_bits = '0;
  endfunction

  // Header bytes: fields are little endian and checked on their last byte.
  function automatic void header_byte(input logic [31:0] pos, input logic [7:0] d);
    logic [31:0] word;
    logic [15:0] half;
    logic [31:0] prod;
    logic [2:0]  code;
    res_t        r;
    hdr_window = {d, hdr_window[63:8]};
    word = hdr_window[63:32];
    half = hdr_window[63:48];
    case (pos)
      POS_SIG: begin
        if (half[7:0] != SIG_B || half[15:8] != SIG_M) fault_bits[ERR_SIG] = 1'b1;
      end
      POS_FSIZE: file_size = word;
      POS_OFFSET: pix_offset = word;
      POS_HDR_SIZE: begin
        if (word != INFO_SIZE) fault_bits[ERR_HDR_SIZE] = 1'b1;
      end
      POS_WIDTH: begin
        if (word > DEF_MAX_WIDTH) fault_bits[ERR_LARGE] = 1'b1;
        else img_w = word;
      end
      POS_HEIGHT: begin
        if (word > DEF_MAX_HEIGHT) fault_bits[ERR_LARGE] = 1'b1;
        else img_h = word;
      end
      POS_PLANES: begin
        if (half != PLANES_ONE) fault_bits[ERR_PLANES] = 1'b1;
      end
      POS_BPP: begin
        if (half != BPP_24) fault_bits[ERR_BPP] = 1'b1;
      end
      POS_COMPRESS: begin
        if (word != 32'd0) fault_bits[ERR_COMPRESS] = 1'b1;
      end
      POS_END: begin
        if (file_size < pix_offset) fault_bits[ERR_FSIZE] = 1'b1;
        if (pix_offset < HEADER_BYTES) fault_bits[ERR_OFFSET] = 1'b1;
        r = '0;
        if (fault_bits != 8'd0) begin
          // The lowest failing check is the one reported.
          code = ERR_LARGE;
          for (int i = 7; i >= 0; i--) begin
            if (fault_bits[i]) code = 3'(i);
          end
          r.result_kind = KIND_REJECT;
          r.error_code  = code;
          phase = PH_DONE;
        end else begin
          r.result_kind  = KIND_ACCEPT;
          r.image_width  = img_w[DIM_W-1:0];
          r.image_height = img_h[DIM_W-1:0];
          chan_cnt = '0;
          col_cnt  = '0;
          row_cnt  = '0;
          if (img_w == 0 || img_h == 0) begin
            phase = PH_DONE;
          end else begin
            prod = (img_h - 32'd1) * img_w;
            row_base = prod[23:0];
            phase = PH_SKIP;
          end
        end
        decoded_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Pixel data: three bytes per pixel, rows padded to a 4-byte file position.
  function automatic void pixel_byte(input logic [31:0] pos, input logic [7:0] d);
    res_t r;
    if (col_cnt >= img_w) begin
      if (pos[1:0] != 2'd0) return;
      col_cnt = '0;
    end
    if (chan_cnt == 2'd0) begin
      held_b = d;
      chan_cnt = 2'd1;
      return;
    end
    if (chan_cnt == 2'd1) begin
      held_g = d;
      chan_cnt = 2'd2;
      return;
    end
    chan_cnt = 2'd0;
    r = '0;
    r.result_kind = KIND_PIXEL;
    r.pixel_index = row_base + col_cnt[23:0];
    r.red         = d;
    r.green       = held_g;
    r.blue        = held_b;
    r.last_pixel  = (row_cnt + 1 == img_h) && (col_cnt + 1 == img_w);
    decoded_q.push_back(r);
    col_cnt = col_cnt + 1;
    if (col_cnt == img_w) begin
      row_cnt = row_cnt + 1;
      if (row_cnt >= img_h) phase = PH_DONE;
      else row_base = row_base - img_w[23:0];
    end
  endfunction

  function automatic void decode_byte(input beat_t b);
    logic [31:0] pos;
    if (b.frame_start) decoder_restart();
    pos = file_pos;
    file_pos = file_pos + 1;
    case (phase)
      PH_HEADER: header_byte(pos, b.data_byte);
      PH_SKIP: begin
        if (pos == pix_offset) begin
          phase = PH_PIXELS;
          pixel_byte(pos, b.data_byte);
        end
      end
      PH_PIXELS: pixel_byte(pos, b.data_byte);
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic int idle_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Monitor: checks result beats against the oldest prediction, then predicts from input beats.
  always @(posedge clk) begin : watch_beats
    res_t  want;
    beat_t b;
    if (rst) begin
      decoder_restart();
      decoded_q.delete();
      byte_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      byte_taken   <= stream_if.valid && stream_if.ready;
      result_taken <= result_if.valid && result_if.ready;
      if (result_if.valid && result_if.ready) begin
        results_seen <= results_seen + 1;
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", result_if.result_kind);
          error_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(result_if.result_kind));
          check_field("pixel_index", 32'(want.pixel_index), 32'(result_if.pixel_index));
          check_field("red", 32'(want.red), 32'(result_if.red));
          check_field("green", 32'(want.green), 32'(result_if.green));
          check_field("blue", 32'(want.blue), 32'(result_if.blue));
          check_field("last_pixel", 32'(want.last_pixel), 32'(result_if.last_pixel));
          check_field("image_width", 32'(want.image_width), 32'(result_if.image_width));
          check_field("image_height", 32'(want.image_height), 32'(result_if.image_height));
          check_field("error_code", 32'(want.error_code), 32'(result_if.error_code));
        end
      end
      if (stream_if.valid && stream_if.ready) begin
        b.data_byte   = stream_if.data_byte;
        b.frame_start = stream_if.frame_start;
        decode_byte(b);
      end
    end
  end

  // Driver: one file byte per beat, with a random gap after each one.
  always @(negedge clk) begin : drive_bytes
    beat_t b;
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else if (stream_if.valid && !byte_taken) begin
      // Beat still waiting for the block: hold it.
    end else if (send_wait != 0) begin
      stream_if.valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (file_bytes_q.size() != 0) begin
      b = file_bytes_q.pop_front();
      stream_if.valid       <= 1'b1;
      stream_if.data_byte   <= b.data_byte;
      stream_if.frame_start <= b.frame_start;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      send_wait <= idle_draw(send_burst);
    end else begin
      stream_if.valid <= 1'b0;
    end
  end

  // Result side: random stall after each beat, and long holds when requested.
  always @(negedge clk) begin : drive_ready
    int n;
    if (rst) begin
      result_if.ready <= 1'b0;
      take_wait <= 0;
    end else if (hold_left != 0) begin
      result_if.ready <= 1'b0;
    end else if (result_taken) begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      n = idle_draw(take_burst);
      if (n == 0) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b0;
        take_wait <= n - 1;
      end
    end else if (take_wait != 0) begin
      result_if.ready <= 1'b0;
      take_wait <= take_wait - 1;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Long receiver hold so the block backs up and stalls its input.
  always @(posedge clk) begin : long_stall
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= LONG_HOLD;
      next_hold_at <= next_hold_at + 200;
    end
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] d, input logic fs);
    beat_t b;
    b.data_byte   = d;
    b.frame_start = fs;
    file_bytes_q.push_back(b);
  endtask

  // Bytes after the end of a file: the block ignores them.
  task automatic put_tail(input int n);
    repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic put_word(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) put_byte(w[8*i +: 8], 1'b0);
  endtask

  task automatic put_header(input logic [15:0] sig, input logic [31:0] fsize, offset, hsize,
                            input logic [31:0] w, h, input logic [15:0] planes, bpp,
                            input logic [31:0] comp);
    put_byte(sig[7:0], 1'b1);
    put_byte(sig[15:8], 1'b0);
    put_word(fsize, 4);
    put_word($urandom, 4);
    put_word(offset, 4);
    put_word(hsize, 4);
    put_word(w, 4);
    put_word(h, 4);
    put_word({16'd0, planes}, 2);
    put_word({16'd0, bpp}, 2);
    put_word(comp, 4);
    repeat (20) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic put_good_header(input int offset, input logic [31:0] w, h);
    put_header({SIG_M, SIG_B}, offset + $urandom_range(0, 3000), offset, INFO_SIZE, w, h,
               PLANES_ONE, BPP_24, 32'd0);
  endtask

  // Filler up to the pixel offset, then rows with padding to the file position.
  task automatic put_image(input int offset, w, h);
    int pos;
    pos = 54;
    while (pos < offset) begin
      put_byte(8'($urandom_range(0, 255)), 1'b0);
      pos++;
    end
    repeat (h) begin
      repeat (3 * w) begin
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        pos++;
      end
      while (pos % 4 != 0) begin
        put_byte(8'($urandom_range(0, 255)), 1'b0);
        pos++;
      end
    end
  endtask

  task automatic put_directed();
    // One-pixel image right after the header, pixel bytes at both extremes.
    put_good_header(54, 1, 1);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_tail(1);
    // Two by two image behind a gap; the odd offset shifts where padding falls.
    put_good_header(61, 2, 2);
    put_image(61, 2, 2);
    put_tail(3);
    // Largest size on one side, zero on the other: accepted with no pixels.
    put_good_header(54, 0, DEF_MAX_HEIGHT);
    put_tail(4);
    put_good_header(54, DEF_MAX_WIDTH, 0);
    // Each header check failing on its own.
    put_header({SIG_M, 8'h62}, 100, 54, INFO_SIZE, 1, 1, PLANES_ONE, BPP_24, 0);
    put_header({SIG_M, SIG_B}, 100, 54, 32'd124, 1, 1, PLANES_ONE, BPP_24, 0);
    put_header({SIG_M, SIG_B}, 60, 64, INFO_SIZE, 1, 1, PLANES_ONE, BPP_24, 0);
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, 1, 1, 16'd0, BPP_24, 0);
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, 1, 1, PLANES_ONE, 16'd32, 0);
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, 1, 1, PLANES_ONE, BPP_24, 1);
    put_header({SIG_M, SIG_B}, 100, 40, INFO_SIZE, 1, 1, PLANES_ONE, BPP_24, 0);
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, DEF_MAX_WIDTH + 1, 1, PLANES_ONE, BPP_24, 0);
    // Negative height read as a huge unsigned value.
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, 1, 32'hFFFF_FFFF, PLANES_ONE, BPP_24, 0);
    // Everything wrong at once: the signature error wins.
    put_header(16'h00FF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
               16'hFFFF, 32'hFFFF_FFFF);
    // Several later checks failing: the planes error wins.
    put_header({SIG_M, SIG_B}, 100, 54, INFO_SIZE, DEF_MAX_WIDTH + 5, 1, 16'd2, 16'd8, 0);
    // A file cut short after its first row, and one cut inside the header.
    put_good_header(54, 3, 2);
    put_image(54, 3, 1);
    put_byte(SIG_B, 1'b1);
    put_word(32'h0000_1234, 4);
  endtask

  // Mostly well-formed files with random content; some with one bad field, cut short or noise.
  task automatic put_random_file();
    int          kind, w, h, offset, start_size, total;
    logic [15:0] sig, planes, bpp;
    logic [31:0] fsize, hsize, comp, wd, ht;
    bit          bad;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      put_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(10, 70)) put_byte(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) w = 0;
      else h = 0;
    end
    offset = ($urandom_range(0, 1) == 0) ? 54 : $urandom_range(55, 70);
    case ($urandom_range(0, 7))
      0: fsize = offset;
      1: fsize = 32'hFFFF_FFFF;
      default: fsize = offset + $urandom_range(1, 100000);
    endcase
    sig    = {SIG_M, SIG_B};
    hsize  = INFO_SIZE;
    planes = PLANES_ONE;
    bpp    = BPP_24;
    comp   = 32'd0;
    wd     = w;
    ht     = h;
    bad    = (kind < 30);
    if (bad) begin
      case ($urandom_range(0, 7))
        ERR_SIG: begin
          if ($urandom_range(0, 1) == 0) sig[7:0] = SIG_B ^ 8'($urandom_range(1, 255));
          else sig[15:8] = SIG_M ^ 8'($urandom_range(1, 255));
        end
        ERR_HDR_SIZE: begin
          hsize = $urandom;
          if (hsize == INFO_SIZE) hsize = 32'd12;
        end
        ERR_FSIZE: fsize = $urandom_range(0, offset - 1);
        ERR_PLANES: planes = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2, 65535));
        ERR_BPP: begin
          bpp = 16'($urandom);
          if (bpp == BPP_24) bpp = 16'd32;
        end
        ERR_COMPRESS: comp = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : ($urandom | 1);
        ERR_OFFSET: offset = $urandom_range(0, 53);
        default: begin
          if ($urandom_range(0, 1) == 0) wd = DEF_MAX_WIDTH + 1 + $urandom_range(0, 100000);
          else ht = $urandom | 32'h8000_0000;
        end
      endcase
    end
    put_header(sig, fsize, offset, hsize, wd, ht, planes, bpp, comp);
    if (bad || w == 0 || h == 0) begin
      put_tail($urandom_range(0, 5));
      return;
    end
    start_size = file_bytes_q.size();
    put_image(offset, w, h);
    if ($urandom_range(0, 9) == 0) begin
      // Cut the file short; the next frame start restarts the parser.
      total = file_bytes_q.size() - start_size;
      repeat ($urandom_range(1, total - 1)) begin
        void'(file_bytes_q.pop_back());
      end
    end else begin
      put_tail($urandom_range(0, 4));
    end
  endtask

  initial begin
    stream_if.valid       = 1'b0;
    stream_if.data_byte   = 8'd0;
    stream_if.frame_start = 1'b0;
    result_if.ready       = 1'b0;
    put_directed();
    while (file_bytes_q.size() < TOTAL_BYTES) put_random_file();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every byte to be taken, every result to arrive, then a short drain.
    while (file_bytes_q.size() != 0 || stream_if.valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
